@@ hw/rtl/kmd_pkg.sv @@
// Shared widths, register codes and lane status type for the key matrix debouncer.
package kmd_pkg;

    // Fixed field widths of the ports
    localparam int ROW_W   = 2;
    localparam int FIELD_W = 11;
    localparam int NOW_W   = 32;
    localparam int DB_W    = 16;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register word index (paddr[2])
    localparam logic REG_DEBOUNCE = 1'b0;

    localparam logic [DB_W-1:0] DEBOUNCE_RESET = 16'd5;

    // Per-column update status from a lane
    typedef struct packed {
        logic obs;        // new observed level
        logic stab;       // new stable level
        logic changed;    // stable level flipped this step
        logic load_time;  // change time takes the current time
    } lane_upd_t;

endpackage

@@ hw/rtl/kmd_apb_regs.sv @@
// APB-style configuration register block holding the debounce time.
module kmd_apb_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kmd_pkg::PADDR_W-1:0]   paddr,
    input  logic [kmd_pkg::PDATA_W-1:0]   pwdata,
    output logic [kmd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [kmd_pkg::DB_W-1:0]      debounce_ms
);
    import kmd_pkg::*;

    logic [DB_W-1:0] debounce_reg;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
        end else if (wr_en && (paddr[2] == REG_DEBOUNCE)) begin
            debounce_reg <= pwdata[DB_W-1:0];
        end
    end

    // Read-back decode
    always_comb begin
        unique case (paddr[2])
            REG_DEBOUNCE: prdata = PDATA_W'(debounce_reg);
            default:      prdata = '0;
        endcase
    end

    assign debounce_ms = debounce_reg;

endmodule

@@ hw/rtl/kmd_lane.sv @@
// One column lane: level change tracking and debounce timeout compare.
module kmd_lane #(
    parameter int TW = 32
) (
    input  logic                     sample,     // new level, 1 = pressed
    input  logic                     obs,        // last observed level
    input  logic                     stab,       // stable level
    input  logic [TW-1:0]            chg_time,   // time of last observed change
    input  logic [TW-1:0]            now,
    input  logic [kmd_pkg::DB_W-1:0] debounce_ms,
    output kmd_pkg::lane_upd_t       upd
);
    import kmd_pkg::*;

    logic          load;
    logic [TW-1:0] t_eff;
    logic [TW-1:0] elapsed;
    logic          ripe;
    logic          flip;

    // A new level restarts the timer
    assign load    = obs ^ sample;
    assign t_eff   = load ? now : chg_time;

    // Wrapping elapsed time against the debounce window
    assign elapsed = now - t_eff;
    assign ripe    = (elapsed >= TW'(debounce_ms));
    assign flip    = (stab ^ sample) && ripe;

    assign upd.obs       = sample;
    assign upd.stab      = stab ^ flip;
    assign upd.changed   = flip;
    assign upd.load_time = load;

endmodule

@@ hw/rtl/key_matrix_debounce_top.sv @@
// Top level of the key matrix debouncer: input stage, lane array, row state, result stage.
//
//  channel  | handshake          | word
//  ---------+--------------------+------------------------------------------
//  s_       | s_valid / s_ready  | s_row_index, s_col_levels, s_now_ms
//  m_       | m_valid / m_ready  | m_out_row, m_stable_pressed, m_stable_changed
//  apb      | psel/penable/pready| paddr, pwdata, prdata (debounce_ms at 0x0)
//
// One word per cycle unless m_ stalls; each result is offered on m_ from the result register.
// Row state is read and written in the same cycle, so back-to-back rows see
// each other's updates with no bypass. Throughput is set by the single lane
// pass per row. Reset clears row state and the per-row timer valid bits;
// a stalled m_ side holds the result stage, then the input stage, then s_ready.
module key_matrix_debounce_top #(
    parameter int ROWS       = 4,
    parameter int COLS       = 11,
    parameter int TIME_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [kmd_pkg::ROW_W-1:0]     s_row_index,
    input  logic [kmd_pkg::FIELD_W-1:0]   s_col_levels,
    input  logic [kmd_pkg::NOW_W-1:0]     s_now_ms,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [kmd_pkg::ROW_W-1:0]     m_out_row,
    output logic [kmd_pkg::FIELD_W-1:0]   m_stable_pressed,
    output logic [kmd_pkg::FIELD_W-1:0]   m_stable_changed,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kmd_pkg::PADDR_W-1:0]   paddr,
    input  logic [kmd_pkg::PDATA_W-1:0]   pwdata,
    output logic [kmd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import kmd_pkg::*;

    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RIW  = ((RW > ROW_W) ? RW : ROW_W) + 1;
    localparam int MAXC = (COLS > FIELD_W) ? COLS : FIELD_W;

    logic [DB_W-1:0] debounce_ms;

    // Input stage
    logic                  s1_valid_reg;
    logic [ROW_W-1:0]      s1_row_reg;
    logic [FIELD_W-1:0]    s1_lvl_reg;
    logic [TIME_WIDTH-1:0] s1_now_reg;

    // Result stage
    logic                  m_valid_reg;
    logic [ROW_W-1:0]      m_row_reg;
    logic [FIELD_W-1:0]    m_pressed_reg;
    logic [FIELD_W-1:0]    m_changed_reg;

    // Row state
    logic [COLS-1:0]                 obs_reg  [ROWS];
    logic [COLS-1:0]                 stab_reg [ROWS];
    logic [COLS-1:0][TIME_WIDTH-1:0] time_reg [ROWS];
    logic [ROWS-1:0]                 time_vld_reg;

    logic                            s_fire;
    logic                            s1_adv;
    logic [RIW-1:0]                  row_ext;
    logic                            row_ok;
    logic [RW-1:0]                   idx;
    logic [MAXC-1:0]                 lvl_ext;
    logic [COLS-1:0]                 sample;
    logic [COLS-1:0]                 obs_cur;
    logic [COLS-1:0]                 stab_cur;
    logic [COLS-1:0][TIME_WIDTH-1:0] time_cur;
    lane_upd_t                       upd [COLS];
    logic [COLS-1:0]                 obs_next;
    logic [COLS-1:0]                 stab_next;
    logic [COLS-1:0]                 chg_next;
    logic [COLS-1:0][TIME_WIDTH-1:0] time_next;
    logic [MAXC-1:0]                 stab_ext;
    logic [MAXC-1:0]                 chg_ext;

    kmd_apb_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .debounce_ms (debounce_ms)
    );

    // Handshake: the input stage moves on when the result stage is free
    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_row_reg <= s_row_index;
            s1_lvl_reg <= s_col_levels;
            s1_now_reg <= s_now_ms[TIME_WIDTH-1:0];
        end
    end

    // Row select and state read
    assign row_ext = RIW'(s1_row_reg);
    assign row_ok  = (row_ext < RIW'(ROWS));
    assign idx     = row_ext[RW-1:0];
    assign lvl_ext = MAXC'(s1_lvl_reg);
    assign sample  = ~lvl_ext[COLS-1:0];

    always_comb begin
        obs_cur  = '0;
        stab_cur = '0;
        time_cur = '0;
        if (row_ok) begin
            obs_cur  = obs_reg[idx];
            stab_cur = stab_reg[idx];
            if (time_vld_reg[idx]) begin
                time_cur = time_reg[idx];
            end
        end
    end

    // Column lanes
    for (genvar c = 0; c < COLS; c++) begin : g_lane
        kmd_lane #(
            .TW (TIME_WIDTH)
        ) u_lane (
            .sample      (sample[c]),
            .obs         (obs_cur[c]),
            .stab        (stab_cur[c]),
            .chg_time    (time_cur[c]),
            .now         (s1_now_reg),
            .debounce_ms (debounce_ms),
            .upd         (upd[c])
        );

        assign obs_next[c]  = upd[c].obs;
        assign stab_next[c] = upd[c].stab;
        assign chg_next[c]  = upd[c].changed;
        assign time_next[c] = upd[c].load_time ? s1_now_reg : time_cur[c];
    end

    // State write-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ROWS; r++) begin
                obs_reg[r]  <= '0;
                stab_reg[r] <= '0;
            end
            time_vld_reg <= '0;
        end else if (s1_adv && row_ok) begin
            obs_reg[idx]      <= obs_next;
            stab_reg[idx]     <= stab_next;
            time_vld_reg[idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && row_ok) begin
            time_reg[idx] <= time_next;
        end
    end

    // Result stage
    assign stab_ext = MAXC'(stab_next);
    assign chg_ext  = MAXC'(chg_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_row_reg     <= s1_row_reg;
            m_pressed_reg <= row_ok ? stab_ext[FIELD_W-1:0] : '0;
            m_changed_reg <= row_ok ? chg_ext[FIELD_W-1:0] : '0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_row        = m_row_reg;
    assign m_stable_pressed = m_pressed_reg;
    assign m_stable_changed = m_changed_reg;

endmodule

@@ tb/sv/tb_key_matrix_debounce_top.sv @@
// Testbench for the key matrix debouncer: scan driver, result checker with row predictor, APB setup.
`timescale 1ns / 1ps

module tb_key_matrix_debounce_top;

    import kmd_pkg::*;

    localparam int N_ROWS      = 4;
    localparam int N_COLS      = 11;
    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [FIELD_W-1:0] levels;
        logic [NOW_W-1:0]   stamp;
    } scan_word_t;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [FIELD_W-1:0] pressed;
        logic [FIELD_W-1:0] changed;
    } row_result_t;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    // Clock, reset and block ports
    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [ROW_W-1:0]   s_row_index  = '0;
    logic [FIELD_W-1:0] s_col_levels = '0;
    logic [NOW_W-1:0]   s_now_ms     = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [ROW_W-1:0]   m_out_row;
    logic [FIELD_W-1:0] m_stable_pressed;
    logic [FIELD_W-1:0] m_stable_changed;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    key_matrix_debounce_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_row_index      (s_row_index),
        .s_col_levels     (s_col_levels),
        .s_now_ms         (s_now_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_row        (m_out_row),
        .m_stable_pressed (m_stable_pressed),
        .m_stable_changed (m_stable_changed),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Predictor state: observed level, stable level and change stamp per cell
    logic [FIELD_W-1:0] seen_lvl   [N_ROWS];
    logic [FIELD_W-1:0] stable_lvl [N_ROWS];
    logic [NOW_W-1:0]   flip_stamp [N_ROWS][N_COLS];
    logic [DB_W-1:0]    debounce_cfg;

    // Stimulus and scoreboard bookkeeping
    scan_word_t  scan_queue[$];
    row_result_t rows_due[$];
    int          scans_total     = 0;
    int          scans_sent      = 0;
    int          results_checked = 0;
    int          fault_count     = 0;
    logic        scan_taken      = 1'b0;
    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;
    int          holds_asked     = 0;
    int          holds_done      = 0;
    int          hold_left       = 0;
    int          stuck           = 0;

    // Random scan generator state
    logic [FIELD_W-1:0] key_state [N_ROWS];
    logic [ROW_W-1:0]   next_row;
    logic [NOW_W-1:0]   ms_clock;

    // Debounce one scanned row and update the cell state
    function automatic row_result_t debounce_row(scan_word_t w);
        logic [FIELD_W-1:0] sample;
        logic [FIELD_W-1:0] obs;
        logic [FIELD_W-1:0] stab;
        logic [FIELD_W-1:0] chg;
        row_result_t        r;
        sample = ~w.levels;
        obs    = seen_lvl[w.row];
        stab   = stable_lvl[w.row];
        chg    = '0;
        for (int c = 0; c < N_COLS; c++) begin
            if (obs[c] != sample[c]) begin
                obs[c] = sample[c];
                flip_stamp[w.row][c] = w.stamp;
            end
            // elapsed time wraps modulo 2^32
            if (stab[c] != obs[c] &&
                (w.stamp - flip_stamp[w.row][c]) >= {16'd0, debounce_cfg}) begin
                stab[c] = obs[c];
                chg[c]  = 1'b1;
            end
        end
        seen_lvl[w.row]   = obs;
        stable_lvl[w.row] = stab;
        r.row     = w.row;
        r.pressed = stab;
        r.changed = chg;
        return r;
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Driver: next word from the queue at the falling edge
    always @(negedge aclk) begin : scan_driver
        scan_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || scan_taken) begin
            if (scan_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                w = scan_queue.pop_front();
                s_valid      <= 1'b1;
                s_row_index  <= w.row;
                s_col_levels <= w.levels;
                s_now_ms     <= w.stamp;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result sink: random stalls plus requested long hold-offs
    always @(negedge aclk) begin : result_sink
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != holds_asked) begin
            holds_done <= holds_done + 1;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on each taken word, check each result word
    always @(posedge aclk) begin : monitor
        scan_word_t  w;
        row_result_t want;
        if (!aresetn) begin
            scan_taken <= 1'b0;
        end else begin
            scan_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                w.row    = s_row_index;
                w.levels = s_col_levels;
                w.stamp  = s_now_ms;
                rows_due.push_back(debounce_row(w));
                scans_sent <= scans_sent + 1;
            end
            if (m_valid && m_ready) begin
                if (rows_due.size() == 0) begin
                    note_fault($sformatf("result word with nothing due: row %0d pressed %h",
                                         m_out_row, m_stable_pressed));
                end else begin
                    want = rows_due.pop_front();
                    results_checked <= results_checked + 1;
                    if (m_out_row !== want.row)
                        note_fault($sformatf("out_row exp %0d got %0d", want.row, m_out_row));
                    if (m_stable_pressed !== want.pressed)
                        note_fault($sformatf("row %0d stable_pressed exp %h got %h",
                                             want.row, want.pressed, m_stable_pressed));
                    if (m_stable_changed !== want.changed)
                        note_fault($sformatf("row %0d stable_changed exp %h got %h",
                                             want.row, want.changed, m_stable_changed));
                end
            end
        end
    end

    // Watchdog: no progress while work is outstanding
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (scans_total == scans_sent && results_checked == scans_sent)) begin
            stuck <= 0;
        end else if (stuck >= STALL_LIMIT) begin
            $display("[key_matrix_debounce_top] ERROR");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    task automatic queue_scan(input logic [ROW_W-1:0] row, input logic [FIELD_W-1:0] levels,
                              input logic [NOW_W-1:0] stamp);
        scan_word_t w;
        w.row    = row;
        w.levels = levels;
        w.stamp  = stamp;
        scan_queue.push_back(w);
        scans_total++;
    endtask

    // Mostly round-robin scans of held keys with bounce, some noise words
    task automatic queue_random_scans(input int count, input int step_max);
        int unsigned        pick;
        int unsigned        lo;
        logic [FIELD_W-1:0] levels;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                queue_scan(ROW_W'($urandom_range(3)), FIELD_W'($urandom), $urandom);
            end else begin
                if (pick < 20)
                    key_state[next_row] ^= FIELD_W'($urandom) & FIELD_W'($urandom);
                levels = key_state[next_row];
                if (pick < 35)
                    levels ^= FIELD_W'(1) << $urandom_range(N_COLS - 1);
                // occasional step right at the debounce boundary
                if (pick >= 95) begin
                    lo = (debounce_cfg == 0) ? 0 : debounce_cfg - 1;
                    ms_clock += $urandom_range(lo, debounce_cfg + 1);
                end else begin
                    ms_clock += $urandom_range(step_max);
                end
                queue_scan(next_row, levels, ms_clock);
                next_row++;
            end
        end
    endtask

    // Wait until every queued word is taken and its result checked
    task automatic drain;
        while (scans_total != scans_sent || results_checked != scans_sent)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [DB_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DEBOUNCE, 2'b00};
        pwdata  <= {16'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        debounce_cfg = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_DEBOUNCE, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {16'd0, debounce_cfg})
            note_fault($sformatf("debounce_ms read exp %h got %h", debounce_cfg, prdata));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_idle(input idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 48 : (mode == IDLE_BOTH) ? 36 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 48 : (mode == IDLE_BOTH) ? 36 : 0;
    endtask

    initial begin : sequencer
        for (int r = 0; r < N_ROWS; r++) begin
            seen_lvl[r]   = '0;
            stable_lvl[r] = '0;
            key_state[r]  = '1;
            for (int c = 0; c < N_COLS; c++)
                flip_stamp[r][c] = '0;
        end
        debounce_cfg = DEBOUNCE_RESET;
        next_row     = '0;
        ms_clock     = 32'd1000;
        set_idle(IDLE_NONE);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset debounce time: press, boundary, bounce, wrap and backwards time
        apb_read_check();
        queue_scan(2'd0, 11'h7FF, 32'd0);
        queue_scan(2'd0, 11'h000, 32'd100);
        queue_scan(2'd0, 11'h000, 32'd104);
        queue_scan(2'd0, 11'h000, 32'd105);
        queue_scan(2'd0, 11'h7FF, 32'd106);
        queue_scan(2'd0, 11'h000, 32'd108);
        queue_scan(2'd3, 11'h555, 32'hFFFF_FFFE);
        queue_scan(2'd3, 11'h555, 32'd3);
        queue_scan(2'd1, 11'h2AA, 32'd50);
        queue_scan(2'd1, 11'h2AA, 32'd40);
        queue_scan(2'd2, 11'h3FF, 32'd7);
        queue_scan(2'd2, 11'h3FF, 32'd11);
        drain();

        // Zero debounce: new level is stable in the same step
        apb_write(16'd0);
        apb_read_check();
        queue_scan(2'd2, 11'h3FF, 32'd11);
        queue_scan(2'd2, 11'h7FE, 32'd11);
        drain();
        queue_random_scans(150, 3);
        drain();

        // Longest debounce, sender idling
        apb_write(16'hFFFF);
        apb_read_check();
        set_idle(IDLE_SEND);
        queue_scan(2'd1, 11'h7FF, 32'd1000);
        queue_scan(2'd1, 11'h7FF, 32'd1000 + 32'd65534);
        queue_scan(2'd1, 11'h7FF, 32'd1000 + 32'd65535);
        queue_scan(2'd0, 11'h7FF, 32'd200);
        queue_scan(2'd0, 11'h7FF, 32'hFFFF_FFFF);
        drain();
        queue_random_scans(120, 2000);
        drain();

        // Mid-range debounce across the time wrap, receiver stalling and held off
        apb_write(16'($urandom_range(2, 40)));
        set_idle(IDLE_RECV);
        ms_clock = 32'hFFFF_FF00;
        queue_random_scans(200, 4);
        holds_asked++;
        drain();
        queue_random_scans(50, 4);
        holds_asked++;
        drain();

        // Debounce of one, both sides idling
        apb_write(16'd1);
        apb_read_check();
        set_idle(IDLE_BOTH);
        queue_random_scans(200, 2);
        drain();

        // Back to the reset value, no idling
        apb_write(DEBOUNCE_RESET);
        set_idle(IDLE_NONE);
        queue_random_scans(160, 3);
        drain();

        repeat (8) @(posedge aclk);
        if (fault_count == 0 && rows_due.size() == 0) begin
            $display("[key_matrix_debounce_top] OK");
        end else begin
            $display("[key_matrix_debounce_top] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/kmd_pkg.sv
hw/rtl/kmd_apb_regs.sv
hw/rtl/kmd_lane.sv
hw/rtl/key_matrix_debounce_top.sv
tb/sv/tb_key_matrix_debounce_top.sv
